// ----- rtl/first_fit_region_allocator_assert.svh -----
// Assertion macros used by the checker file
`ifndef FIRST_FIT_REGION_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_REGION_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define FFRA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define FFRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ffra_pkg.sv -----
package ffra_pkg;

  // Operation codes carried in the input item
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CHECK = 2'd2,
    OP_NOP = 2'd3
  } op_t;

  // Update applied to the whole chain in the commit cycle
  typedef enum logic [1:0] {
    CMT_NONE = 2'd0,
    CMT_INSERT = 2'd1,
    CMT_APPEND = 2'd2,
    CMT_REMOVE = 2'd3
  } commit_t;

  // Configuration register indexes
  localparam logic CFG_POOL_BASE = 1'b0;
  localparam logic CFG_POOL_SIZE = 1'b1;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned WIDE_W = 33;
  localparam int unsigned PAGES_W = 21;

  // One list entry held by a cell
  typedef struct packed {
    logic              v;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] len;
  } entry_t;

  // Search wave handed from cell to cell
  typedef struct packed {
    logic              active;
    logic [WIDE_W-1:0] cand;
    logic              found;
    logic [ADDR_W-1:0] len;
  } wave_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    op_t               op;
    logic [WIDE_W-1:0] need;
    logic [ADDR_W-1:0] addr;
    commit_t           kind;
    logic [ADDR_W-1:0] new_start;
    logic [ADDR_W-1:0] new_len;
  } bus_t;

endpackage

// ----- rtl/first_fit_region_allocator.sv -----
// Channel  | Dir | Payload
// s_axis   | in  | operation, request_size, address
// m_axis   | out | result_address, success, pages_freed
// cfg      | in  | pool_base (index 0), pool_size (index 1)
//
// For each item the search wave walks the cell chain one cell per cycle;
// then the result is decided and registered, and the commit shifts the chain.
// Reset clears all entry valid bits and the control state.
// Input is taken only when the chain is free; a result held in the output
// register while m_tready is low stalls only the delivery of the next one.
// PAGE_BYTES must be a power of two.
module first_fit_region_allocator #(
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned MAX_REGIONS = 64,
  parameter int unsigned HEADER_PAGES = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // operation[1:0], request_size[33:2], address[65:34], zero fill
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // result_address[31:0], success[32], pages_freed[53:33], zero fill
  output logic [55:0] m_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned PB_LOG2 = $clog2(PAGE_BYTES);
  localparam int unsigned AW = ffra_pkg::ADDR_W;
  localparam int unsigned WW = ffra_pkg::WIDE_W;
  localparam int unsigned PW = ffra_pkg::PAGES_W;
  localparam logic [WW-1:0] HDR_BYTES = WW'(HEADER_PAGES * PAGE_BYTES);
  localparam logic [WW-1:0] PAGE_W = WW'(PAGE_BYTES);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_COMMIT = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state;
  logic [AW-1:0] pool_base;
  logic [AW-1:0] pool_size;
  ffra_pkg::op_t op;
  logic [WW-1:0] need;
  logic [AW-1:0] addr;
  ffra_pkg::commit_t kind;
  logic [AW-1:0] res_addr;
  logic res_ok;
  logic [PW-1:0] res_pages;
  ffra_pkg::commit_t kind_next;
  logic [AW-1:0] res_addr_next;
  logic res_ok_next;
  logic [PW-1:0] res_pages_next;

  ffra_pkg::bus_t bus;
  ffra_pkg::wave_t waves [MAX_REGIONS+1];
  ffra_pkg::entry_t ents [MAX_REGIONS];
  ffra_pkg::entry_t lefts [MAX_REGIONS];
  ffra_pkg::entry_t rights [MAX_REGIONS];

  logic accept;
  logic [AW-1:0] req_in;
  logic [WW-1:0] header_end;
  logic [WW-1:0] pool_sum;
  logic [WW-1:0] pool_end;
  logic [AW-1:0] len_pages;
  ffra_pkg::wave_t tail;
  logic full;
  logic hdr_hit;

  assign accept = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign req_in = s_tdata[33:2];
  assign header_end = {1'b0, pool_base} + HDR_BYTES;
  assign pool_sum = {1'b0, pool_base} + {1'b0, pool_size};
  assign pool_end = pool_sum[AW] ? {1'b1, {AW{1'b0}}} : pool_sum;
  assign tail = waves[MAX_REGIONS];
  assign full = ents[MAX_REGIONS-1].v;
  assign hdr_hit = (addr >= pool_base) && ({1'b0, addr} < header_end);
  assign len_pages = tail.len >> PB_LOG2;

  // Drive the broadcast to the cells
  always_comb begin
    bus.op = op;
    bus.need = need;
    bus.addr = addr;
    bus.kind = (state == ST_COMMIT) ? kind : ffra_pkg::CMT_NONE;
    bus.new_start = res_addr;
    bus.new_len = need[AW-1:0];
  end

  // Inject the search wave on accept
  assign waves[0] = '{active: accept, cand: header_end, found: 1'b0, len: '0};

  // Build the row of cells
  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lefts[i] = '{v: 1'b1, start: '0, len: '0};
    end else begin : g_mid
      assign lefts[i] = ents[i-1];
    end
    if (i == MAX_REGIONS - 1) begin : g_last
      assign rights[i] = '{v: 1'b0, start: '0, len: '0};
    end else begin : g_inner
      assign rights[i] = ents[i+1];
    end
    ffra_cell u_cell (
      .clk(clk),
      .rst(rst),
      .bus(bus),
      .wave_in(waves[i]),
      .left(lefts[i]),
      .right(rights[i]),
      .wave_out(waves[i+1]),
      .ent(ents[i])
    );
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
      pool_size <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ffra_pkg::CFG_POOL_BASE: begin
          pool_base <= cfg_data;
        end
        ffra_pkg::CFG_POOL_SIZE: begin
          pool_size <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // Decide the result from the wave leaving the chain
  always_comb begin
    kind_next = ffra_pkg::CMT_NONE;
    res_addr_next = '0;
    res_ok_next = 1'b0;
    res_pages_next = '0;
    case (op)
      ffra_pkg::OP_ALLOC: begin
        if (!full && !need[AW]) begin
          if (tail.found) begin
            kind_next = ffra_pkg::CMT_INSERT;
            res_addr_next = tail.cand[AW-1:0];
            res_ok_next = 1'b1;
          end else if ((tail.cand <= pool_end) &&
                       ((pool_end - tail.cand) >= need)) begin
            kind_next = ffra_pkg::CMT_APPEND;
            res_addr_next = tail.cand[AW-1:0];
            res_ok_next = 1'b1;
          end
        end
      end
      ffra_pkg::OP_RELEASE: begin
        if (tail.found) begin
          kind_next = ffra_pkg::CMT_REMOVE;
          res_ok_next = 1'b1;
          res_pages_next = (len_pages[AW-1:PW] != '0) ? {PW{1'b1}} :
                           len_pages[PW-1:0];
        end
      end
      ffra_pkg::OP_CHECK: begin
        res_ok_next = tail.found || hdr_hit;
      end
      default: begin
      end
    endcase
  end

  // Sequence scan, commit and delivery
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
      kind <= ffra_pkg::CMT_NONE;
    end else begin
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            op <= ffra_pkg::op_t'(s_tdata[1:0]);
            need <= {1'b0, (req_in >> PB_LOG2) << PB_LOG2} + PAGE_W;
            addr <= s_tdata[65:34];
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (tail.active) begin
            kind <= kind_next;
            res_addr <= res_addr_next;
            res_ok <= res_ok_next;
            res_pages <= res_pages_next;
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {2'b00, res_pages, res_ok, res_addr};
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/ffra_cell.sv -----
module ffra_cell (
  input  logic           clk,
  input  logic           rst,
  input  ffra_pkg::bus_t   bus,
  input  ffra_pkg::wave_t  wave_in,
  input  ffra_pkg::entry_t left,
  input  ffra_pkg::entry_t right,
  output ffra_pkg::wave_t  wave_out,
  output ffra_pkg::entry_t ent
);

  ffra_pkg::wave_t wave;
  logic mark;
  logic past;

  logic [ffra_pkg::WIDE_W-1:0] s_wide;
  logic [ffra_pkg::WIDE_W-1:0] e_wide;
  logic alloc_fit;
  logic rel_hit;
  logic chk_hit;
  logic hit;

  // Evaluate this entry against the passing wave
  always_comb begin
    s_wide = {1'b0, ent.start};
    e_wide = s_wide + {1'b0, ent.len};
    alloc_fit = ent.v && (bus.op == ffra_pkg::OP_ALLOC) && (s_wide >= wave.cand) &&
                ((s_wide - wave.cand) >= bus.need);
    rel_hit = ent.v && (bus.op == ffra_pkg::OP_RELEASE) && (ent.start == bus.addr);
    chk_hit = ent.v && (bus.op == ffra_pkg::OP_CHECK) && (bus.addr >= ent.start) &&
              ((bus.addr - ent.start) < ent.len);
    hit = wave.active && !wave.found && (alloc_fit || rel_hit || chk_hit);
    wave_out.active = wave.active;
    wave_out.found = wave.found || hit;
    wave_out.len = hit ? ent.len : wave.len;
    wave_out.cand = wave.cand;
    // Advance the candidate past this region's end until a hole is found
    if (ent.v && (bus.op == ffra_pkg::OP_ALLOC) && !wave.found && !alloc_fit &&
        (e_wide > wave.cand)) begin
      wave_out.cand = e_wide;
    end
  end

  // Hold the wave and the marks left by it
  always_ff @(posedge clk) begin
    if (rst) begin
      wave.active <= 1'b0;
    end else begin
      wave.active <= wave_in.active;
    end
    wave.cand <= wave_in.cand;
    wave.found <= wave_in.found;
    wave.len <= wave_in.len;
    if (wave.active) begin
      mark <= hit;
      past <= wave.found;
    end
  end

  // Shift, insert or drop entries on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      ent.v <= 1'b0;
    end else begin
      case (bus.kind)
        ffra_pkg::CMT_INSERT: begin
          if (mark) begin
            ent <= '{v: 1'b1, start: bus.new_start, len: bus.new_len};
          end else if (past) begin
            ent <= left;
          end
        end
        ffra_pkg::CMT_APPEND: begin
          if (!ent.v && left.v) begin
            ent <= '{v: 1'b1, start: bus.new_start, len: bus.new_len};
          end
        end
        ffra_pkg::CMT_REMOVE: begin
          if (mark || past) begin
            ent <= right;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/ffra_checker.sv -----
`include "first_fit_region_allocator_assert.svh"

module ffra_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);

  logic [31:0] r_addr;
  logic        r_ok;
  logic [20:0] r_pages;

  assign r_addr = m_tdata[31:0];
  assign r_ok = m_tdata[32];
  assign r_pages = m_tdata[53:33];

  // Busy after an accepted item
  `FFRA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
  // Hold a stalled result
  `FFRA_ASSERT_NEXT(a_hold_result, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "dropped")
  // Failed items carry zero address and zero pages
  `FFRA_ASSERT_SAME(a_fail_zero, m_tvalid && !r_ok, (r_addr == '0) && (r_pages == '0), "fail set")
  // An allocated address never comes with freed pages
  `FFRA_ASSERT_SAME(a_addr_no_pages, m_tvalid && (r_addr != '0), r_pages == '0, "addr and pages")

endmodule

bind first_fit_region_allocator ffra_checker u_ffra_checker (.*);

// ----- tb/tb_first_fit_region_allocator.sv -----
`timescale 1ns / 1ps

import ffra_pkg::*;

// Expected reply for one request
typedef struct {
  bit [31:0] addr;
  bit        ok;
  bit [20:0] pages;
} alloc_reply_t;

// Tracks the region list and queues the replies it must produce
class region_book;
  localparam longint unsigned PAGE = 4096;
  localparam int unsigned LIST_MAX = 64;
  localparam longint unsigned HDR_PAGES = 5;
  localparam longint unsigned SPACE = 64'h1_0000_0000;
  localparam longint unsigned PAGES_SAT = 64'h1F_FFFF;

  bit [31:0]    pool_base;
  bit [31:0]    pool_size;
  bit [31:0]    reg_start[LIST_MAX];
  bit [31:0]    reg_len[LIST_MAX];
  int           count;
  alloc_reply_t replies[$];
  int           errors;

  function new();
    pool_base = 0;
    pool_size = 0;
    count = 0;
    errors = 0;
  endfunction

  function longint unsigned header_end();
    return longint'(pool_base) + HDR_PAGES * PAGE;
  endfunction

  // First-fit search and ordered insertion
  function bit allocate(bit [31:0] req, output bit [31:0] where);
    longint unsigned need, pend, cand, s, e;
    int pos;
    where = 0;
    need = (longint'(req) / PAGE + 1) * PAGE;
    pend = longint'(pool_base) + longint'(pool_size);
    cand = header_end();
    pos = count;
    if (pend > SPACE) pend = SPACE;
    if (count >= LIST_MAX || need >= SPACE) return 0;
    for (int i = 0; i < count; i++) begin
      s = reg_start[i];
      e = s + longint'(reg_len[i]);
      if (s >= cand && s - cand >= need) begin
        pos = i;
        break;
      end
      if (e > cand) cand = e;
    end
    if (pos == count && (cand > pend || pend - cand < need)) return 0;
    for (int i = count; i > pos; i--) begin
      reg_start[i] = reg_start[i-1];
      reg_len[i] = reg_len[i-1];
    end
    reg_start[pos] = cand[31:0];
    reg_len[pos] = need[31:0];
    count++;
    where = cand[31:0];
    return 1;
  endfunction

  // Remove the region with an exact base match
  function bit release_region(bit [31:0] addr, output bit [20:0] pages);
    longint unsigned p;
    pages = 0;
    for (int i = 0; i < count; i++) begin
      if (reg_start[i] == addr) begin
        p = longint'(reg_len[i]) / PAGE;
        pages = (p > PAGES_SAT) ? PAGES_SAT[20:0] : p[20:0];
        for (int j = i; j + 1 < count; j++) begin
          reg_start[j] = reg_start[j+1];
          reg_len[j] = reg_len[j+1];
        end
        count--;
        return 1;
      end
    end
    return 0;
  endfunction

  function bit legit(bit [31:0] addr);
    longint unsigned a, s;
    a = addr;
    if (a >= pool_base && a < header_end()) return 1;
    for (int i = 0; i < count; i++) begin
      s = reg_start[i];
      if (a >= s && a - s < longint'(reg_len[i])) return 1;
    end
    return 0;
  endfunction

  // Apply one accepted request and queue its reply
  function void note_request(op_t op, bit [31:0] req, bit [31:0] addr);
    alloc_reply_t r;
    r = '{addr: 0, ok: 0, pages: 0};
    case (op)
      OP_ALLOC:   r.ok = allocate(req, r.addr);
      OP_RELEASE: r.ok = release_region(addr, r.pages);
      OP_CHECK:   r.ok = legit(addr);
      default:    ;
    endcase
    replies.push_back(r);
  endfunction

  // Compare one delivered reply with the oldest queued one
  function void compare_reply(logic [55:0] d);
    alloc_reply_t r;
    if (replies.size() == 0) begin
      $display("%0t: unexpected reply %h", $time, d);
      errors++;
      return;
    end
    r = replies.pop_front();
    if (d[31:0] !== r.addr) begin
      $display("%0t: result_address expected %h actual %h", $time, r.addr, d[31:0]);
      errors++;
    end
    if (d[32] !== r.ok) begin
      $display("%0t: success expected %b actual %b", $time, r.ok, d[32]);
      errors++;
    end
    if (d[53:33] !== r.pages) begin
      $display("%0t: pages_freed expected %0d actual %0d", $time, r.pages, d[53:33]);
      errors++;
    end
  endfunction
endclass

module tb_first_fit_region_allocator;
  localparam int DRAIN_CYCLES = 80;

  // Idle modes
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // operation, request_size, address, zero fill
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // result_address, success, pages_freed, zero fill
  logic [55:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  region_book book = new();
  int idle_mode = IDLE_NONE;

  first_fit_region_allocator uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receive replies and stall at random
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) book.compare_reply(m_tdata);
    case (idle_mode)
      IDLE_RECV: m_tready <= ($urandom_range(99) >= 79);
      IDLE_BOTH: m_tready <= ($urandom_range(99) >= 18);
      default:   m_tready <= 1'b1;
    endcase
  end

  // Send one item; called right after a rising edge
  task automatic send_item(op_t op, bit [31:0] req, bit [31:0] addr);
    int gap;
    int pct;
    gap = 0;
    pct = (idle_mode == IDLE_SEND) ? 79 : (idle_mode == IDLE_BOTH) ? 18 : 0;
    while ($urandom_range(99) < pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, addr, req, op};
    do @(posedge clk); while (!s_tready);
    book.note_request(op, req, addr);
  endtask

  // Hold the sender until every reply has arrived
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (book.replies.size() != 0) @(posedge clk);
  endtask

  // Write both pool registers while the block is idle
  task automatic set_pool(bit [31:0] base, bit [31:0] size);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_POOL_BASE;
    cfg_data <= base;
    @(posedge clk);
    cfg_index <= CFG_POOL_SIZE;
    cfg_data <= size;
    @(posedge clk);
    cfg_we <= 1'b0;
    book.pool_base = base;
    book.pool_size = size;
  endtask

  // Random item, biased toward well-formed use of the list
  task automatic random_item(int alloc_pct);
    int pick;
    int k;
    bit [31:0] req;
    bit [31:0] addr;
    op_t op;
    pick = $urandom_range(99);
    req = $urandom;
    addr = $urandom;
    if (pick < alloc_pct) begin
      op = OP_ALLOC;
      k = $urandom_range(9);
      if (k < 8) req = $urandom_range(3 * 4096);
      else if (k == 8) req = 32'hFFFF_F000 | $urandom_range(4095);
    end else if (pick < alloc_pct + (95 - alloc_pct) / 2) begin
      op = OP_RELEASE;
      if (book.count > 0 && $urandom_range(3) != 0)
        addr = book.reg_start[$urandom_range(book.count - 1)];
      else if ($urandom_range(3) == 0)
        addr = book.pool_base;
    end else if (pick < 95) begin
      op = OP_CHECK;
      k = $urandom_range(3);
      if (book.count > 0 && k < 2) begin
        k = $urandom_range(book.count - 1);
        addr = book.reg_start[k] + $urandom_range(book.reg_len[k]);
      end else if (k == 2)
        addr = book.pool_base + $urandom_range(6 * 4096) - 4096;
    end else
      op = OP_NOP;
    send_item(op, req, addr);
  endtask

  initial begin
    bit [31:0] b;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: header bounds, rounding, region end, release cases
    set_pool(32'h0001_0000, 32'h0010_0000);
    send_item(OP_CHECK, 0, 32'h0001_0000);
    send_item(OP_CHECK, 0, 32'h0000_FFFF);
    send_item(OP_CHECK, 0, 32'h0001_4FFF);
    send_item(OP_CHECK, 0, 32'h0001_5000);
    send_item(OP_RELEASE, 0, 32'h0001_0000);
    send_item(OP_RELEASE, 0, 32'h1234_5678);
    send_item(OP_ALLOC, 0, 0);
    send_item(OP_ALLOC, 4095, 0);
    send_item(OP_ALLOC, 4096, 0);
    send_item(OP_CHECK, 0, 32'h0001_5FFF);
    send_item(OP_CHECK, 0, 32'h0001_9000);
    send_item(OP_RELEASE, 0, 32'h0001_5000);
    send_item(OP_ALLOC, 0, 0);
    send_item(OP_ALLOC, 32'hFFFF_FFFF, 0);
    send_item(OP_ALLOC, 32'h0010_0000, 0);
    send_item(OP_RELEASE, 0, 32'h0001_7000);
    send_item(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Header outside an empty pool
    set_pool(32'h0, 32'h0);
    send_item(OP_ALLOC, 0, 0);
    send_item(OP_CHECK, 0, 32'h0);
    // Pool end clipped at the top of the address space
    set_pool(32'hFFF0_0000, 32'hFFFF_FFFF);
    send_item(OP_ALLOC, 32'h000F_9FFF, 0);
    send_item(OP_CHECK, 0, 32'hFFFF_FFFF);
    send_item(OP_ALLOC, 0, 0);
    // Header wrapping past the address space
    set_pool(32'hFFFF_F000, 32'hFFFF_FFFF);
    send_item(OP_ALLOC, 0, 0);
    send_item(OP_CHECK, 0, 32'hFFFF_F800);
    send_item(OP_RELEASE, 0, 32'hFFF0_5000);

    // Random phases across idle modes and pool settings
    for (int ph = 0; ph < 8; ph++) begin
      idle_mode = ph % 4;
      case (ph % 4)
        0: set_pool(32'h0004_0000, 32'h0010_0000);
        1: begin
          b = $urandom;
          set_pool(b, $urandom_range(32'h0020_0000));
        end
        2: set_pool(32'h0, 32'hFFFF_FFFF);
        default: set_pool(32'hFF80_0000 | $urandom_range(4095), 32'hFFFF_FFFF);
      endcase
      for (int n = 0; n < 160; n++) begin
        if (ph == 2 && n == 80) wait_drained();
        random_item((ph % 2 == 0) ? 65 : 40);
      end
    end

    // Drain and report
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.errors == 0 && book.replies.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/ffra_pkg.sv
rtl/ffra_cell.sv
rtl/first_fit_region_allocator.sv
rtl/ffra_checker.sv
tb/tb_first_fit_region_allocator.sv
